FILE: src/quaternion_multiply_normalize_defines.svh
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_defines
// Assertion macros shared by the quaternion product block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_NORMALIZE_DEFINES_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_DEFINES_SVH

// Check cons in the same cycle as ante, outside reset
`define QMN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, with no reset exclusion
`define QMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared types, constants and the 32-bit clip for the quaternion product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qmn_pkg;

  localparam int DEF_FRAC_BITS = 28;

  // Four 32-bit components, w in the lowest bits, then x, y, z
  typedef logic [3:0][31:0] quat_t;

  // Word that rides along the pipeline
  typedef struct packed {
    quat_t c;
    logic  sat;
    logic  big;
  } item_t;

  typedef struct packed {
    logic [31:0] v;
    logic        sat;
  } clip_t;

  // Operand selection of the Hamilton product, entry 4*k+j for component k,
  // term j, two bits each: index into b, index into a, and the subtract flag
  localparam logic [31:0] B_SEL = 32'h9C78E4E4;
  localparam logic [31:0] A_SEL = 32'h63D2B1E4;
  localparam logic [15:0] T_NEG = 16'h888E;

  localparam logic signed [65:0] CLIP_MAX = 66'sd2147483647;
  localparam logic signed [65:0] CLIP_MIN = -66'sd2147483648;

  // Clip a wide signed value to the 32-bit range
  function automatic clip_t clip66(input logic signed [65:0] v);
    clip_t res;
    if (v > CLIP_MAX) begin
      res.v   = 32'h7FFF_FFFF;
      res.sat = 1'b1;
    end else if (v < CLIP_MIN) begin
      res.v   = 32'h8000_0000;
      res.sat = 1'b1;
    end else begin
      res.v   = v[31:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: src/qmn_product.sv
// ----------------------------------------------------------------------------
// qmn_product
// Eight-stage pipeline: Hamilton product, rounding, clip, squared magnitude
// and threshold compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qmn_product #(
  parameter int FRAC_BITS = qmn_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  qmn_pkg::quat_t    a,
  input  qmn_pkg::quat_t    b,
  input  logic [30:0]       thr,
  output logic              out_valid,
  output qmn_pkg::item_t    item,
  output logic [63:0]       m2
);
  import qmn_pkg::*;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic                     vld [8];
  logic signed [63:0]       prod [16];
  logic signed [65:0]       s2 [4][2];
  logic signed [65:0]       s3 [4];
  quat_t                    c4;
  logic                     sat4;
  quat_t                    c5;
  logic                     sat5;
  logic [63:0]              sq [4];
  quat_t                    c6;
  logic                     sat6;
  logic [63:0]              ps [2];
  quat_t                    c7;
  logic                     sat7;
  logic [63:0]              m2_7;
  logic [64:0]              tot;
  clip_t                    cl [4];
  logic [63:0]              thr_sh;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 8; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < 8; s++) vld[s] <= vld[s-1];
    end
  end

  // Stage 1: sixteen products
  for (genvar t = 0; t < 16; t++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        prod[t] <= $signed(b[B_SEL[2*t +: 2]]) * $signed(a[A_SEL[2*t +: 2]]);
      end
    end
  end

  // Stage 2: signed pair sums; stage 3: full sum plus rounding half
  for (genvar k = 0; k < 4; k++) begin : g_sum
    for (genvar h = 0; h < 2; h++) begin : g_pair
      localparam int T0 = 4 * k + 2 * h;
      logic signed [65:0] e0, e1;
      assign e0 = T_NEG[T0]     ? -66'(prod[T0])     : 66'(prod[T0]);
      assign e1 = T_NEG[T0 + 1] ? -66'(prod[T0 + 1]) : 66'(prod[T0 + 1]);
      always_ff @(posedge clk) begin
        if (en) s2[k][h] <= e0 + e1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) s3[k] <= s2[k][0] + s2[k][1] + HALF;
    end
    assign cl[k] = clip66(s3[k] >>> FRAC_BITS);
  end

  assign tot    = {1'b0, ps[0]} + {1'b0, ps[1]};
  assign thr_sh = 64'(thr) << FRAC_BITS;

  // Stages 4 to 8: clip, square, add, saturate, compare
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) c4[k] <= cl[k].v;
      sat4 <= cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;

      for (int k = 0; k < 4; k++) sq[k] <= 64'($signed(c4[k]) * $signed(c4[k]));
      c5   <= c4;
      sat5 <= sat4;

      ps[0] <= sq[0] + sq[1];
      ps[1] <= sq[2] + sq[3];
      c6    <= c5;
      sat6  <= sat5;

      m2_7 <= tot[64] ? '1 : tot[63:0];
      c7   <= c6;
      sat7 <= sat6;

      item.c   <= c7;
      item.sat <= sat7;
      item.big <= m2_7 > thr_sh;
      m2       <= m2_7;
    end
  end

  assign out_valid = vld[7];

endmodule

FILE: src/qmn_isqrt.sv
// ----------------------------------------------------------------------------
// qmn_isqrt
// Floor square root of a 64-bit value, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qmn_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       m2,
  input  qmn_pkg::item_t    item_in,
  output logic              out_valid,
  output logic [31:0]       root,
  output qmn_pkg::item_t    item_out
);
  import qmn_pkg::*;

  localparam int NS = 32;

  logic        vld  [NS];
  logic [63:0] rem  [NS];
  logic [63:0] res  [NS];
  item_t       meta [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic        v_in;
    logic [63:0] rem_in, res_in;
    item_t       meta_in;
    logic [64:0] trial;
    logic        ge;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = m2;
      assign res_in  = '0;
      assign meta_in = item_in;
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign rem_in  = rem[s-1];
      assign res_in  = res[s-1];
      assign meta_in = meta[s-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign ge    = {1'b0, rem_in} >= trial;

    // Try the next root bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? rem_in - trial[63:0] : rem_in;
        res[s]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
        meta[s] <= meta_in;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign root      = res[NS-1][31:0];
  assign item_out  = meta[NS-1];

endmodule

FILE: src/qmn_divide.sv
// ----------------------------------------------------------------------------
// qmn_divide
// Four-lane restoring divider: components times 2^FRAC_BITS over the root,
// rounded to nearest, then sign, clip and select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qmn_divide #(
  parameter int FRAC_BITS = qmn_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       root,
  input  qmn_pkg::item_t    item_in,
  output logic              out_valid,
  output qmn_pkg::item_t    item_out
);
  import qmn_pkg::*;

  // The quotient stays below 2^(FRAC_BITS+1) because the root is at least
  // the magnitude of each component
  localparam int QW = FRAC_BITS + 2;

  logic              p_vld;
  logic [63:0]       p_num [4];
  logic [3:0]        p_neg;
  logic [31:0]       p_div;
  item_t             p_item;
  logic [31:0]       p_mag [4];

  logic              vld  [QW];
  logic [63:0]       rem  [QW][4];
  logic [QW-1:0]     quo  [QW][4];
  logic [3:0]        neg  [QW];
  logic [31:0]       dv   [QW];
  item_t             meta [QW];

  logic [31:0]       d0;
  clip_t             cl [4];

  assign d0 = (root == 32'd0) ? 32'd1 : root;

  // Take the 32-bit magnitude of each component
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p_mag[l] = item_in.c[l][31] ? (~item_in.c[l] + 32'd1) : item_in.c[l];
    end
  end

  // Prepare dividends with the rounding half added
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        p_neg[l] <= item_in.c[l][31];
        p_num[l] <= (64'(p_mag[l]) << FRAC_BITS) + 64'(d0 >> 1);
      end
      p_div  <= d0;
      p_item <= item_in;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int SH = QW - 1 - i;
    logic        v_in;
    logic [31:0] d_in;
    logic [3:0]  n_in;
    item_t       m_in;
    logic [63:0] dsh;

    if (i == 0) begin : g_first
      assign v_in = p_vld;
      assign d_in = p_div;
      assign n_in = p_neg;
      assign m_in = p_item;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign d_in = dv[i-1];
      assign n_in = neg[i-1];
      assign m_in = meta[i-1];
    end

    assign dsh = 64'(d_in) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [63:0]   r_in;
      logic [QW-1:0] q_in;
      logic          ge;

      if (i == 0) begin : g_first
        assign r_in = p_num[l];
        assign q_in = '0;
      end else begin : g_next
        assign r_in = rem[i-1][l];
        assign q_in = quo[i-1][l];
      end

      assign ge = r_in >= dsh;

      // Subtract the shifted divisor where it fits
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i][l] <= ge ? r_in - dsh : r_in;
          quo[i][l] <= {q_in[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i]   <= d_in;
        neg[i]  <= n_in;
        meta[i] <= m_in;
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_clip
    logic signed [65:0] qs;
    assign qs    = $signed(66'(quo[QW-1][l]));
    assign cl[l] = clip66(neg[QW-1][l] ? -qs : qs);
  end

  // Select scaled or plain components, hold as the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        item_out.c[l] <= meta[QW-1].big ? cl[l].v : meta[QW-1].c[l];
      end
      item_out.big <= meta[QW-1].big;
      item_out.sat <= meta[QW-1].sat |
                      (meta[QW-1].big & (cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat));
    end
  end

endmodule

FILE: src/quaternion_multiply_normalize.sv
// One word per cycle in and out unless a held output word is not taken. The
// pipeline holds 8 stages of product, rounding, squared magnitude and compare,
// 32 stages of square root (one root bit each), a divider set-up stage,
// FRAC_BITS + 2 divider stages (one quotient bit each) and the output register.
// The whole pipeline advances when the output register is empty or taken, so
// s_tready follows m_tready. The result is b * a; when the squared magnitude
// exceeds norm_threshold, each component is divided by its square root.
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Top level: stream ports, threshold register, pipeline stall control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_multiply_normalize_defines.svh"

module quaternion_multiply_normalize #(
  parameter int FRAC_BITS = qmn_pkg::DEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [255:0]  s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // r_w, r_x, r_y, r_z
  output logic [1:0]    m_tuser,   // was_scaled, saturated
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data   // norm_threshold
);
  import qmn_pkg::*;

  localparam logic [30:0] THR_RESET =
    31'(((64'd101 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic [30:0] norm_threshold;
  logic        en;
  logic        p_vld, q_vld;
  item_t       p_item, q_item, o_item;
  logic [63:0] p_m2;
  logic [31:0] q_root;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_threshold <= THR_RESET;
    end else if (cfg_valid) begin
      norm_threshold <= cfg_data;
    end
  end

  // Advance everything unless a held output word is not taken
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  qmn_product #(.FRAC_BITS(FRAC_BITS)) u_product (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .a        (s_tdata[127:0]),
    .b        (s_tdata[255:128]),
    .thr      (norm_threshold),
    .out_valid(p_vld),
    .item     (p_item),
    .m2       (p_m2)
  );

  qmn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_vld),
    .m2       (p_m2),
    .item_in  (p_item),
    .out_valid(q_vld),
    .root     (q_root),
    .item_out (q_item)
  );

  qmn_divide #(.FRAC_BITS(FRAC_BITS)) u_divide (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_vld),
    .root     (q_root),
    .item_in  (q_item),
    .out_valid(m_tvalid),
    .item_out (o_item)
  );

  assign m_tdata    = o_item.c;
  assign m_tuser[0] = o_item.big;
  assign m_tuser[1] = o_item.sat;

  // A normalized word has its w and x components within one
  `QMN_ASSERT_NOW(a_norm_w, m_tvalid && m_tuser[0], ($signed(m_tdata[31:0]) <= ONE_Q) && ($signed(m_tdata[31:0]) >= -ONE_Q), "normalized w out of unit range")
  `QMN_ASSERT_NOW(a_norm_x, m_tvalid && m_tuser[0], ($signed(m_tdata[63:32]) <= ONE_Q) && ($signed(m_tdata[63:32]) >= -ONE_Q), "normalized x out of unit range")
  // Reset empties the pipeline
  `QMN_ASSERT_NEXT(a_rst_empty, rst, !m_tvalid, "output valid right after reset")

endmodule
